>>> rtl/core/hs_pkg.sv
// Shared types and constants for the chained hash set.
`default_nettype none

package hs_pkg;

   // Fixed field widths
   localparam int KEY_W   = 31;
   localparam int COUNT_W = 4;
   localparam int OP_W    = 2;

   // Request codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // Delete count saturates here
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUOT,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]  req_type;
      logic [KEY_W-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic               found;
      logic               rejected;
      logic [COUNT_W-1:0] removed_count;
   } rsp_item_type;

   // One slot of the table: valid flag and stored key
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } entry_type;

   // Shared subtract and compare unit
   typedef struct packed {
      logic [KEY_W-1:0] a;
      logic [KEY_W-1:0] b;
   } alu_in_type;

   typedef struct packed {
      logic [KEY_W-1:0] diff;
      logic             ge;
      logic             eq;
   } alu_out_type;

endpackage

`default_nettype wire

>>> rtl/core/hs_alu.sv
// Shared subtract and compare unit used for the remainder steps and the slot compares.
`default_nettype none

module hs_alu (
   input  wire hs_pkg::alu_in_type alu_i,
   output hs_pkg::alu_out_type     alu_o
);
   import hs_pkg::*;

   logic [KEY_W:0] sub;

   // Subtract with borrow out; no borrow means a >= b
   assign sub = {1'b0, alu_i.a} - {1'b0, alu_i.b};

   assign alu_o.diff = sub[KEY_W-1:0];
   assign alu_o.ge   = ~sub[KEY_W];
   assign alu_o.eq   = (alu_i.a == alu_i.b);

endmodule

`default_nettype wire

>>> rtl/core/hs_store.sv
// Slot storage: one write or read address a cycle, registered read data.
`default_nettype none

module hs_store #(
   parameter int DEPTH = 88,
   parameter int AW    = 7
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     addr,
   input  wire hs_pkg::entry_type wr_data,
   output hs_pkg::entry_type      rd_data
);
   import hs_pkg::*;

   entry_type slot_mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port and registered read port share the address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/chained_hash_set.sv
// Top level of the chained hash set: sequencer, reciprocal remainder and bucket scan.
//
//   channel   ports                         handshake
//   request   start, busy, req_data         taken when start && !busy
//   response  rsp_valid, rsp_data           one-cycle strobe, no backpressure
//
// A request runs a reciprocal multiply for the quotient (ST_QUOT), then the shared
// subtractor for key - quotient*BUCKETS (ST_MOD), then for a known code a scan of
// k <= SLOTS slots, each a read and then a compare and write back; insert stops at
// the first free slot and a query at the first hit. The response follows in the next cycle.
// After reset the block clears all BUCKETS*SLOTS slots, one a cycle, busy high.
// Results cannot be stalled; busy stays high until the response strobe is done.
`default_nettype none

module chained_hash_set #(
   parameter int BUCKETS = 11,
   parameter int SLOTS   = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire hs_pkg::req_item_type req_data,
   output logic                      rsp_valid,
   output hs_pkg::rsp_item_type      rsp_data
);
   import hs_pkg::*;

   localparam int TOTAL = BUCKETS * SLOTS;
   localparam int AW    = $clog2(TOTAL);
   localparam int BW    = $clog2(BUCKETS);
   localparam int SCW   = $clog2(SLOTS + 1);

   // Quotient by reciprocal: ceil(2^(KEY_W+BW) / BUCKETS), exact for every key
   localparam int              SHIFT      = KEY_W + BW;
   localparam logic [63:0]     RECIP_FULL = ((64'd1 << SHIFT) + 64'(BUCKETS - 1))
                                            / 64'(BUCKETS);
   localparam logic [KEY_W:0]  RECIP_M    = RECIP_FULL[KEY_W:0];

   state_type state_ff, state_in;

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [BW-1:0]      rem_ff, rem_in;
   logic [KEY_W-1:0]   quot_ff, quot_in;
   logic [SCW-1:0]     slot_cnt_ff, slot_cnt_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic               found_ff, found_in;
   logic               rejected_ff, rejected_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   alu_in_type  alu_i;
   alu_out_type alu_o;

   logic          mem_wr_en;
   logic [AW-1:0] mem_addr;
   entry_type     mem_wr_data;
   entry_type     rd_entry;

   logic [2*KEY_W:0] product;
   logic [KEY_W-1:0] quot_mul;
   logic [AW-1:0]    scan_addr;
   logic             accept;
   logic             match;
   logic             last_slot;
   logic             clr_last;
   logic             op_known;
   logic             scan_done;

   hs_alu u_alu (
      .alu_i (alu_i),
      .alu_o (alu_o)
   );

   hs_store #(
      .DEPTH (TOTAL),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (rd_entry)
   );

   // Status terms shared by the sequencer and the datapath
   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      product   = (2*KEY_W+1)'(key_ff) * (2*KEY_W+1)'(RECIP_M);
      quot_mul  = quot_ff * KEY_W'(BUCKETS);
      scan_addr = AW'(rem_ff) * AW'(SLOTS) + AW'(slot_cnt_ff);
      match     = rd_entry.valid && alu_o.eq;
      last_slot = (slot_cnt_ff == SCW'(SLOTS - 1));
      clr_last  = (clr_cnt_ff == AW'(TOTAL - 1));
      op_known  = (op_ff == OP_INSERT) || (op_ff == OP_QUERY) || (op_ff == OP_DELETE);
      scan_done = last_slot
                  || ((op_ff == OP_INSERT) && !rd_entry.valid)
                  || ((op_ff == OP_QUERY) && match);
   end

   // Shared unit operands: remainder subtract or key compare
   always_comb begin
      if (state_ff == ST_MOD) begin
         alu_i.a = key_ff;
         alu_i.b = quot_mul;
      end else begin
         alu_i.a = key_ff;
         alu_i.b = rd_entry.key;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_QUOT;
         end
         ST_QUOT: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            state_in = op_known ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = scan_done ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs and storage control
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      rsp_valid   = (state_ff == ST_RESP);
      rsp_data.found         = found_ff;
      rsp_data.rejected      = rejected_ff;
      rsp_data.removed_count = count_ff;
      mem_wr_en   = 1'b0;
      mem_addr    = scan_addr;
      mem_wr_data = '{valid: 1'b0, key: key_ff};
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_addr    = clr_cnt_ff;
            mem_wr_data = '0;
         end
         ST_CHECK: begin
            if ((op_ff == OP_INSERT) && !rd_entry.valid) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = '{valid: 1'b1, key: key_ff};
            end else if ((op_ff == OP_DELETE) && match) begin
               mem_wr_en = 1'b1;
            end
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      key_in      = key_ff;
      op_in       = op_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      slot_cnt_in = slot_cnt_ff;
      clr_cnt_in  = clr_cnt_ff;
      found_in    = found_ff;
      rejected_in = rejected_ff;
      count_in    = count_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               key_in      = req_data.key;
               op_in       = req_data.req_type;
               rem_in      = '0;
               slot_cnt_in = '0;
               found_in    = 1'b0;
               rejected_in = 1'b0;
               count_in    = '0;
            end
         end
         ST_QUOT: begin
            // Quotient is the high part of key times the reciprocal
            quot_in = KEY_W'(product >> SHIFT);
         end
         ST_MOD: begin
            // Remainder is key less quotient*BUCKETS, always below BUCKETS
            rem_in = alu_o.diff[BW-1:0];
         end
         ST_CHECK: begin
            slot_cnt_in = slot_cnt_ff + 1'b1;
            if ((op_ff == OP_INSERT) && rd_entry.valid && last_slot) begin
               rejected_in = 1'b1;
            end
            if ((op_ff == OP_QUERY) && match) begin
               found_in = 1'b1;
            end
            if ((op_ff == OP_DELETE) && match && (count_ff != COUNT_MAX)) begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      op_ff       <= op_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      slot_cnt_ff <= slot_cnt_in;
      found_ff    <= found_in;
      rejected_ff <= rejected_in;
      count_ff    <= count_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/hs_checker.sv
// Port-level checks for the chained hash set, bound to the top level.
`default_nettype none

module hs_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 rsp_valid,
   input wire hs_pkg::rsp_item_type rsp_data
);
   import hs_pkg::*;

   // Clearing pass keeps the block busy right after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // A taken request is followed by busy and no stray response
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request taken but block not busy");

   // Response strobe lasts one cycle and the block then frees up
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response strobe not followed by idle");

   // A response is only shown while busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // At most one field of a response is set
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_data.found, rsp_data.rejected,
                                 (rsp_data.removed_count != '0)}) <= 1))
      else $error("response sets more than one field");

endmodule

bind chained_hash_set hs_checker u_hs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/tb.sv
// Testbench for chained_hash_set: directed and random requests checked against a bucket model.
`timescale 1ns / 1ps

import hs_pkg::*;

// Scoreboard: mirrors the bucket table and queues the expected responses
class hash_set_scoreboard #(int BUCKETS = 11, int SLOTS = 8);
   logic [KEY_W-1:0] slot_key [BUCKETS*SLOTS];
   bit               slot_used [BUCKETS*SLOTS];
   rsp_item_type     expected_rsps [$];
   int               errors;

   function new();
      errors = 0;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_key[i]  = '0;
      end
   endfunction

   function int pending();
      return expected_rsps.size();
   endfunction

   // Apply one accepted request to the table and queue its response
   function void note_request(req_item_type req);
      rsp_item_type rsp;
      int           base;
      int           hits;
      bit           placed;
      rsp    = '0;
      base   = int'(req.key % BUCKETS) * SLOTS;
      hits   = 0;
      placed = 1'b0;
      case (req.req_type)
         OP_INSERT: begin
            // lowest free slot wins
            for (int s = 0; s < SLOTS; s++) begin
               if (!placed && !slot_used[base + s]) begin
                  slot_used[base + s] = 1'b1;
                  slot_key[base + s]  = req.key;
                  placed = 1'b1;
               end
            end
            rsp.rejected = !placed;
         end
         OP_QUERY: begin
            for (int s = 0; s < SLOTS; s++)
               if (slot_used[base + s] && slot_key[base + s] == req.key)
                  rsp.found = 1'b1;
         end
         OP_DELETE: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (slot_used[base + s] && slot_key[base + s] == req.key) begin
                  slot_used[base + s] = 1'b0;
                  hits++;
               end
            end
            // count saturates
            rsp.removed_count = (hits > COUNT_MAX) ? COUNT_MAX : COUNT_W'(hits);
         end
         default: begin
            // unused code: no state change, all-zero response
         end
      endcase
      expected_rsps.push_back(rsp);
   endfunction

   // Compare one response with the oldest expectation
   function void check_response(rsp_item_type rsp);
      rsp_item_type exp_rsp;
      if (expected_rsps.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: response with nothing expected: found=%0b rejected=%0b removed=%0d",
                     $time, rsp.found, rsp.rejected, rsp.removed_count);
         return;
      end
      exp_rsp = expected_rsps.pop_front();
      if (rsp.found !== exp_rsp.found || rsp.rejected !== exp_rsp.rejected ||
          rsp.removed_count !== exp_rsp.removed_count) begin
         errors++;
         if (errors <= 10)
            $display("%0t: mismatch: expected found=%0b rejected=%0b removed=%0d, got found=%0b rejected=%0b removed=%0d",
                     $time, exp_rsp.found, exp_rsp.rejected, exp_rsp.removed_count,
                     rsp.found, rsp.rejected, rsp.removed_count);
      end
   endfunction
endclass

module tb;
   localparam int BUCKETS = 11;
   localparam int SLOTS   = 8;
   localparam int RANDOM_REQS = 450;
   localparam int POOL_SIZE   = 20;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_data;
   logic         rsp_valid;
   rsp_item_type rsp_data;

   hash_set_scoreboard #(BUCKETS, SLOTS) sb;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   chained_hash_set #(
      .BUCKETS(BUCKETS),
      .SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_response(rsp_data);
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("chained_hash_set test failed");
      $finish;
   end

   // Present one request after gap idle cycles; returns at the falling edge after acceptance
   task send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key, input int gap);
      req_item_type req;
      req.req_type = op;
      req.key      = key;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(req);
      @(negedge clock);
   endtask

   // Hold the request side idle until every response is back
   task drain_responses();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [3:0]       hot_bucket [4];
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      int               pick;
      int               gap;
      bit               burst;

      sb       = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: key extremes, every code, full bucket, multi-copy delete
      send_request(OP_INSERT, '0, 0);
      send_request(OP_INSERT, KEY_MAX, 1);
      send_request(OP_QUERY, '0, 0);
      send_request(OP_QUERY, KEY_MAX, 0);
      send_request(OP_QUERY, KEY_W'(11), 2);
      send_request(OP_UNUSED, KEY_MAX, 0);
      for (int i = 0; i < SLOTS + 1; i++)
         send_request(OP_INSERT, KEY_W'(5), i % 3);
      send_request(OP_QUERY, KEY_W'(5), 0);
      send_request(OP_DELETE, KEY_W'(5), 0);
      send_request(OP_DELETE, KEY_W'(5), 3);
      send_request(OP_QUERY, KEY_W'(5), 0);
      send_request(OP_DELETE, '0, 0);
      send_request(OP_DELETE, KEY_MAX, 0);
      send_request(OP_QUERY, KEY_MAX, 0);
      drain_responses();

      // Key pool packed into a few hot buckets so they fill and collide
      foreach (hot_bucket[i])
         hot_bucket[i] = 4'($urandom_range(0, BUCKETS - 1));
      foreach (key_pool[i])
         key_pool[i] = KEY_W'($urandom_range(0, 195225785) * 11 + hot_bucket[i % 4]);

      // Random requests
      burst = 1'b0;
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 40 == 0)
            burst = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_REQS / 2)
            drain_responses();
         pick = $urandom_range(0, 99);
         if (pick < 42)
            op = OP_INSERT;
         else if (pick < 68)
            op = OP_QUERY;
         else if (pick < 94)
            op = OP_DELETE;
         else
            op = OP_UNUSED;
         if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            key = KEY_W'($urandom);
         gap = burst ? 0 : $urandom_range(0, 17);
         send_request(op, key, gap);
      end

      // Wind down
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("chained_hash_set test passed");
      end else begin
         $display("chained_hash_set test failed");
      end
      $finish;
   end
endmodule
